FILE: rtl/core/iirdf2_pkg.sv
`default_nettype none
package iirdf2_pkg;

	localparam int COEF_W     = 16;
	localparam int COEF_FRAC  = 13;
	localparam int STATE_W    = 24;
	localparam int DIGIT_W    = 4;
	localparam int NUM_DIGITS = COEF_W / DIGIT_W;
	localparam int DCNT_W     = $clog2(NUM_DIGITS);
	localparam int PROD_W     = STATE_W + COEF_W;
	localparam int ACC_W      = 44;
	localparam int NUM_REGS   = 7;
	localparam int REG_IDX_W  = 3;

	localparam logic [REG_IDX_W-1:0] IDX_B0 = 3'd0;
	localparam logic [REG_IDX_W-1:0] IDX_A1 = 3'd4;

	localparam logic [COEF_W-1:0] B0_RESET = 16'sd8192;

	localparam logic [COEF_FRAC-1:0] ROUND_BIAS = 13'h1000;

	typedef struct packed {
		logic init;
		logic load;
		logic step;
		logic accum;
		logic sub;
	} mac_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/core/iirdf2_mac.sv
`default_nettype none
module iirdf2_mac import iirdf2_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire mac_ctl_t           ctl,
	input  wire logic [ACC_W-1:0]   init_val,
	input  wire logic [STATE_W-1:0] operand,
	input  wire logic [COEF_W-1:0]  coef,
	output logic      [ACC_W-1:0]   acc
);

	logic signed [ACC_W-1:0]       acc_q;
	logic signed [PROD_W-1:0]      p_q;
	logic signed [STATE_W-1:0]     opnd_q;
	logic        [COEF_W-1:0]      coef_q;
	logic                          first_q;
	logic        [DIGIT_W-1:0]     digit;
	logic signed [DIGIT_W:0]       digit_ext;
	logic signed [STATE_W+DIGIT_W:0] prod;
	logic signed [PROD_W-1:0]      p_next;

	assign digit     = coef_q[COEF_W-1 -: DIGIT_W];
	assign digit_ext = first_q ? {digit[DIGIT_W-1], digit} : {1'b0, digit};
	assign prod      = opnd_q * digit_ext;

	always_comb begin
		if (first_q) begin
			p_next = PROD_W'(prod);
		end else begin
			p_next = (p_q <<< DIGIT_W) + PROD_W'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q <= 1'b0;
		end else if (ctl.load) begin
			first_q <= 1'b1;
		end else if (ctl.step) begin
			first_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			opnd_q <= operand;
			coef_q <= coef;
		end else if (ctl.step) begin
			coef_q <= coef_q << DIGIT_W;
		end
		if (ctl.step) begin
			p_q <= p_next;
		end
		if (ctl.init) begin
			acc_q <= init_val;
		end else if (ctl.accum) begin
			acc_q <= ctl.sub ? acc_q - ACC_W'(p_q) : acc_q + ACC_W'(p_q);
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

FILE: rtl/core/iir_direct_form_two_filter_unit.sv
`default_nettype none
// channel | handshake                | payload
// --------+--------------------------+-------------------------------
// input   | in_valid / in_ready      | sample_in [SAMPLE_WIDTH]
// output  | out_valid / out_ready    | sample_out [SAMPLE_WIDTH]
// config  | cfg_valid / cfg_ready    | cfg_index [3], cfg_data [16]
//
// Each request runs its 2*ORDER+1 products one after another, each as a series
// of 4-bit digit steps followed by an accumulate step, through the single
// 24x4-bit digit multiplier of the MAC.
// Reset clears the delay line and loads b0 = 1.0, all other coefficients 0.
// A finished result moves to the output register once it is free and waits there;
// the next request is taken as soon as the result moves, and only the hand-off stalls on out_ready.
module iir_direct_form_two_filter_unit import iirdf2_pkg::*; #(
	parameter int ORDER        = 3,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    in_valid,
	output logic                         in_ready,
	input  wire logic [SAMPLE_WIDTH-1:0] sample_in,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output logic      [SAMPLE_WIDTH-1:0] sample_out,
	input  wire logic                    cfg_valid,
	output logic                         cfg_ready,
	input  wire logic [REG_IDX_W-1:0]    cfg_index,
	input  wire logic [COEF_W-1:0]       cfg_data
);

	localparam int TERM_W    = $clog2(ORDER + 1);
	localparam int DLY_IDX_W = (ORDER > 1) ? $clog2(ORDER) : 1;
	localparam int SH_W      = ACC_W - COEF_FRAC;

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_STEP = 5'b00010,
		S_ACC  = 5'b00100,
		S_NODE = 5'b01000,
		S_DONE = 5'b10000
	} state_t;

	state_t                   state_q, state_d;
	logic [TERM_W-1:0]        term_q;
	logic                     phase_q;
	logic [DCNT_W-1:0]        dcnt_q;
	logic [COEF_W-1:0]        coef_q [NUM_REGS];
	logic [STATE_W-1:0]       dly_q [ORDER];
	logic [STATE_W-1:0]       w_q;
	logic                     out_valid_q;
	logic [SAMPLE_WIDTH-1:0]  out_q;

	mac_ctl_t                 ctl;
	logic [ACC_W-1:0]         init_val;
	logic [ACC_W-1:0]         acc;
	logic                     sel_phase;
	logic [TERM_W-1:0]        sel_term;
	logic [TERM_W-1:0]        dly_sel;
	logic [REG_IDX_W-1:0]     coef_idx;
	logic [STATE_W-1:0]       operand;
	logic [SH_W-1:0]          acc_sh;
	logic [STATE_W-1:0]       w_sat;
	logic [SAMPLE_WIDTH-1:0]  y_sat;
	logic                     accept;
	logic                     deliver;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid & in_ready;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign sample_out = out_q;
	assign deliver   = (state_q == S_DONE) && (!out_valid_q || out_ready);

	assign acc_sh = acc[ACC_W-1:COEF_FRAC];

	always_comb begin
		if (acc_sh[SH_W-1:STATE_W-1] != {(SH_W-STATE_W+1){acc_sh[SH_W-1]}}) begin
			w_sat = {acc_sh[SH_W-1], {(STATE_W-1){~acc_sh[SH_W-1]}}};
		end else begin
			w_sat = acc_sh[STATE_W-1:0];
		end
		if (acc_sh[SH_W-1:SAMPLE_WIDTH-1] !=
				{(SH_W-SAMPLE_WIDTH+1){acc_sh[SH_W-1]}}) begin
			y_sat = {acc_sh[SH_W-1], {(SAMPLE_WIDTH-1){~acc_sh[SH_W-1]}}};
		end else begin
			y_sat = acc_sh[SAMPLE_WIDTH-1:0];
		end
	end

	always_comb begin
		dly_sel = sel_term - TERM_W'(1);
		if (sel_phase) begin
			coef_idx = IDX_B0 + REG_IDX_W'(sel_term);
		end else begin
			coef_idx = IDX_A1 + REG_IDX_W'(dly_sel);
		end
		if (sel_phase && (sel_term == '0)) begin
			operand = w_sat;
		end else begin
			operand = dly_q[dly_sel[DLY_IDX_W-1:0]];
		end
	end

	always_comb begin
		state_d   = state_q;
		ctl       = '0;
		init_val  = {{(ACC_W-COEF_FRAC){1'b0}}, ROUND_BIAS};
		sel_phase = phase_q;
		sel_term  = term_q;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					ctl.init  = 1'b1;
					ctl.load  = 1'b1;
					init_val  = {{(ACC_W-SAMPLE_WIDTH-COEF_FRAC){sample_in[SAMPLE_WIDTH-1]}},
						sample_in, ROUND_BIAS};
					sel_phase = 1'b0;
					sel_term  = TERM_W'(1);
					state_d   = S_STEP;
				end
			end
			S_STEP: begin
				ctl.step = 1'b1;
				if (dcnt_q == DCNT_W'(NUM_DIGITS - 1)) begin
					state_d = S_ACC;
				end
			end
			S_ACC: begin
				ctl.accum = 1'b1;
				ctl.sub   = ~phase_q;
				if (term_q == TERM_W'(ORDER)) begin
					state_d = phase_q ? S_DONE : S_NODE;
				end else begin
					ctl.load = 1'b1;
					sel_term = term_q + TERM_W'(1);
					state_d  = S_STEP;
				end
			end
			S_NODE: begin
				ctl.init  = 1'b1;
				ctl.load  = 1'b1;
				sel_phase = 1'b1;
				sel_term  = '0;
				state_d   = S_STEP;
			end
			S_DONE: begin
				if (deliver) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			term_q      <= '0;
			phase_q     <= 1'b0;
			dcnt_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ctl.load) begin
				term_q  <= sel_term;
				phase_q <= sel_phase;
				dcnt_q  <= '0;
			end else if (ctl.step) begin
				dcnt_q <= dcnt_q + DCNT_W'(1);
			end
			if (deliver) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_REGS; k++) begin
				coef_q[k] <= (REG_IDX_W'(k) == IDX_B0) ? B0_RESET : '0;
			end
		end else if (cfg_valid && cfg_ready && (cfg_index < REG_IDX_W'(NUM_REGS))) begin
			coef_q[cfg_index] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < ORDER; k++) begin
				dly_q[k] <= '0;
			end
		end else if (deliver) begin
			dly_q[0] <= w_q;
			for (int k = 1; k < ORDER; k++) begin
				dly_q[k] <= dly_q[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_NODE) begin
			w_q <= w_sat;
		end
		if (deliver) begin
			out_q <= y_sat;
		end
	end

	iirdf2_mac u_mac (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.init_val (init_val),
		.operand  (operand),
		.coef     (coef_q[coef_idx]),
		.acc      (acc)
	);

endmodule
`default_nettype wire
